// File: rtl/table_linear_interpolator_defines.svh
// Assertion helpers for the interpolator; clk and rst_n must be in scope where used.
`ifndef TABLE_LINEAR_INTERPOLATOR_DEFINES_SVH
`define TABLE_LINEAR_INTERPOLATOR_DEFINES_SVH

// Same-cycle implication.
`define TLI_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tli: same-cycle check failed");

// Next-cycle implication.
`define TLI_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tli: next-cycle check failed");

`endif

// File: rtl/tli_pkg.sv
package tli_pkg;

    localparam int TABLE_DEPTH_DEF = 256;
    localparam int POINT_WIDTH_DEF = 40;

    // Fixed field widths
    localparam int INDEX_FIELD_W = 8;
    localparam int POINT_FIELD_W = 40;
    localparam int VALUE_W       = 32;
    localparam int RESULT_W      = 48;
    localparam int GAIN_W        = 10;
    localparam int CFG_DATA_W    = 10;
    localparam int CFG_INDEX_W   = 1;

    // Arithmetic widths: capped quotient, interpolated value, gain product
    localparam int QUOT_CAP_BIT = 50;
    localparam int M_W          = QUOT_CAP_BIT + 1;
    localparam int V_W          = M_W + 2;
    localparam int GP_W         = 64;

    localparam logic signed [GP_W-1:0] RES_MAX = 64'sh0000_7FFF_FFFF_FFFF;
    localparam logic signed [GP_W-1:0] RES_MIN = 64'shFFFF_8000_0000_0000;

    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
    localparam cfg_index_t CFG_LAST_INDEX = 1'b0;
    localparam cfg_index_t CFG_GAIN       = 1'b1;

    localparam logic [INDEX_FIELD_W-1:0] LAST_INDEX_RESET = 8'd205;
    localparam logic [GAIN_W-1:0]        GAIN_RESET       = 10'd100;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef logic [1:0] region_t;
    localparam region_t REGION_INSIDE = 2'd0;
    localparam region_t REGION_BELOW  = 2'd1;
    localparam region_t REGION_ABOVE  = 2'd2;

    typedef struct packed {
        logic                     opcode;
        logic [INDEX_FIELD_W-1:0] entry_index;
        logic [POINT_FIELD_W-1:0] entry_point;
        logic [VALUE_W-1:0]       entry_value;
        logic [POINT_FIELD_W-1:0] query_point;
    } tli_in_t;

    typedef struct packed {
        logic signed [RESULT_W-1:0] result_value;
        logic [INDEX_FIELD_W-1:0]   segment_low;
        region_t                    region;
        logic                       div_fault;
    } tli_out_t;

    typedef struct packed {
        logic capture;
        logic slot_calc;
        logic mem_write;
        logic search;
        logic fetch_hi;
        logic cap_lo;
        logic prep;
        logic mul_lo;
        logic mul_hi;
        logic div_step;
        logic combine;
        logic scale;
        logic out_load;
    } tli_cmd_t;

    typedef struct packed {
        logic in_is_query;
        logic search_done;
        logic fault;
        logic div_done;
        logic out_free;
    } tli_status_t;

endpackage

// File: rtl/tli_datapath.sv
`include "table_linear_interpolator_defines.svh"

module tli_datapath
    import tli_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int POINT_WIDTH = POINT_WIDTH_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  tli_in_t                  in_item,
    input  tli_cmd_t                 cmd,
    output tli_status_t              status,
    input  logic [INDEX_FIELD_W-1:0] last_index,
    input  logic [GAIN_W-1:0]        gain,
    output logic                     out_valid,
    input  logic                     out_ready,
    output tli_out_t                 out_item
);

    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int WIDE_IDX_W  = (IDX_W > INDEX_FIELD_W) ? IDX_W : INDEX_FIELD_W;
    localparam int WIDE_PT_W   = (POINT_WIDTH > POINT_FIELD_W) ? POINT_WIDTH : POINT_FIELD_W;
    localparam int PROD_W      = POINT_WIDTH + VALUE_W;
    localparam int CNT_W       = $clog2(PROD_W);
    localparam int CAP_CMP_W   = (PROD_W > M_W) ? PROD_W : M_W;
    localparam int HALF_W      = VALUE_W / 2;
    localparam int PART_W      = POINT_WIDTH + HALF_W;
    // Slot wrap: idx mod DEPTH by reciprocal multiply, exact for 8-bit indexes
    localparam int RECIP_SHIFT = 24;
    localparam int RECIP_W     = 23;
    localparam int SLOT_PROD_W = INDEX_FIELD_W + RECIP_W;
    localparam int QUOT_W      = SLOT_PROD_W - RECIP_SHIFT;
    localparam logic [RECIP_W-1:0] RECIP_C =
        RECIP_W'(((1 << RECIP_SHIFT) + TABLE_DEPTH - 1) / TABLE_DEPTH);
    localparam logic [CAP_CMP_W-1:0] QUOT_CAP = CAP_CMP_W'(1) << QUOT_CAP_BIT;

    logic [POINT_WIDTH-1:0] point_mem [TABLE_DEPTH];
    logic [VALUE_W-1:0]     value_mem [TABLE_DEPTH];

    tli_in_t                  in_reg;
    logic [QUOT_W-1:0]        slot_quot_reg;
    logic [IDX_W-1:0]         addr_reg;
    logic [IDX_W-1:0]         cmp_idx_reg;
    logic                     cmp_valid_reg;
    logic                     cmp_valid_next;
    logic [IDX_W-1:0]         seg_lo_reg;
    logic                     idx_zero_reg;
    logic                     idx_last_reg;
    logic [POINT_WIDTH-1:0]   pt_rd_reg;
    logic [VALUE_W-1:0]       val_rd_reg;
    logic [POINT_WIDTH-1:0]   x1_reg;
    logic [VALUE_W-1:0]       y1_reg;
    logic [POINT_WIDTH-1:0]   dx_reg;
    logic [POINT_WIDTH-1:0]   dq_reg;
    logic [VALUE_W-1:0]       dy_reg;
    logic                     neg_reg;
    logic                     fault_reg;
    region_t                  region_reg;
    logic [PROD_W-1:0]        prod_reg;
    logic [POINT_WIDTH-1:0]   rem_reg;
    logic [CNT_W-1:0]         div_cnt_reg;
    logic signed [V_W-1:0]    v_reg;
    logic signed [GP_W-1:0]   gp_reg;
    tli_out_t                 out_item_reg;
    logic                     out_valid_reg;
    logic                     out_valid_next;

    logic [IDX_W-1:0]         last_eff;
    logic [WIDE_PT_W-1:0]     q_wide;
    logic [WIDE_PT_W-1:0]     ep_wide;
    logic [POINT_WIDTH-1:0]   q;
    logic [POINT_WIDTH-1:0]   ep;
    logic [SLOT_PROD_W-1:0]   slot_prod;
    logic [INDEX_FIELD_W-1:0] slot_base;
    logic [INDEX_FIELD_W-1:0] slot_rem;
    logic [WIDE_IDX_W-1:0]    slot_wide;
    logic [IDX_W-1:0]         slot;
    logic                     found;
    logic                     at_end;
    logic                     hit;
    logic [IDX_W-1:0]         rd_addr;
    logic [HALF_W-1:0]        dy_half;
    logic [PART_W-1:0]        part_prod;
    logic [POINT_WIDTH:0]     rem_shift;
    logic [POINT_WIDTH:0]     rem_diff;
    logic                     rem_ge;
    logic [CAP_CMP_W-1:0]     quot_ext;
    logic [CAP_CMP_W-1:0]     quot_cap;
    logic [M_W-1:0]           m;
    logic signed [V_W-1:0]    v_next;
    logic signed [GAIN_W:0]   gain_s;
    logic signed [GP_W-1:0]   gp_next;
    logic signed [GP_W-1:0]   sat;
    logic [WIDE_IDX_W-1:0]    seg_wide;
    logic                     below;
    logic                     above;

    always_comb
    begin
        if (last_index == '0)
            last_eff = IDX_W'(1);
        else if (int'(last_index) > TABLE_DEPTH - 1)
            last_eff = IDX_W'(TABLE_DEPTH - 1);
        else
            last_eff = IDX_W'(last_index);
    end

    assign q_wide  = WIDE_PT_W'(in_reg.query_point);
    assign ep_wide = WIDE_PT_W'(in_reg.entry_point);
    assign q       = q_wide[POINT_WIDTH-1:0];
    assign ep      = ep_wide[POINT_WIDTH-1:0];

    assign slot_prod = SLOT_PROD_W'(in_reg.entry_index) * SLOT_PROD_W'(RECIP_C);
    assign slot_base = INDEX_FIELD_W'(int'(slot_quot_reg) * TABLE_DEPTH);
    assign slot_rem  = in_reg.entry_index - slot_base;
    assign slot_wide = WIDE_IDX_W'(slot_rem);
    assign slot      = slot_wide[IDX_W-1:0];

    // Search compares the word read in the previous cycle
    assign found = q <= pt_rd_reg;
    assign at_end = cmp_idx_reg == (last_eff - IDX_W'(1));
    assign hit = cmd.search && cmp_valid_reg && (found || at_end);
    assign cmp_valid_next = cmd.search && !hit;

    always_comb
    begin
        if (cmd.search)
            rd_addr = addr_reg;
        else if (cmd.fetch_hi)
            rd_addr = seg_lo_reg + IDX_W'(1);
        else
            rd_addr = seg_lo_reg;
    end

    assign below = idx_zero_reg && (q < x1_reg);
    assign above = idx_last_reg && (q > pt_rd_reg);

    // One narrow multiplier, low half of dy first, then the high half
    assign dy_half   = cmd.mul_hi ? dy_reg[VALUE_W-1:HALF_W] : dy_reg[HALF_W-1:0];
    assign part_prod = {{HALF_W{1'b0}}, dq_reg} * {{POINT_WIDTH{1'b0}}, dy_half};

    assign rem_shift = {rem_reg, prod_reg[PROD_W-1]};
    assign rem_diff  = rem_shift - {1'b0, dx_reg};
    assign rem_ge    = rem_shift >= {1'b0, dx_reg};

    assign quot_ext = CAP_CMP_W'(prod_reg);
    assign quot_cap = (quot_ext > QUOT_CAP) ? QUOT_CAP : quot_ext;
    assign m = fault_reg ? '0 : quot_cap[M_W-1:0];
    assign v_next = neg_reg ? (V_W'(y1_reg) - V_W'(m)) : (V_W'(y1_reg) + V_W'(m));

    assign gain_s  = $signed({1'b0, gain});
    assign gp_next = GP_W'(v_reg) * GP_W'(gain_s);

    always_comb
    begin
        if (gp_reg > RES_MAX)
            sat = RES_MAX;
        else if (gp_reg < RES_MIN)
            sat = RES_MIN;
        else
            sat = gp_reg;
    end

    assign seg_wide = WIDE_IDX_W'(seg_lo_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.mem_write)
        begin
            point_mem[slot] <= ep;
            value_mem[slot] <= in_reg.entry_value;
        end
        pt_rd_reg  <= point_mem[rd_addr];
        val_rd_reg <= value_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            in_reg   <= in_item;
            addr_reg <= '0;
        end
        if (cmd.slot_calc)
            slot_quot_reg <= slot_prod[SLOT_PROD_W-1:RECIP_SHIFT];
        if (cmd.search)
        begin
            addr_reg    <= addr_reg + IDX_W'(1);
            cmp_idx_reg <= addr_reg;
        end
        if (hit)
        begin
            if (found)
            begin
                seg_lo_reg   <= (cmp_idx_reg == '0) ? '0 : cmp_idx_reg - IDX_W'(1);
                idx_zero_reg <= cmp_idx_reg == '0;
                idx_last_reg <= 1'b0;
            end
            else
            begin
                seg_lo_reg   <= last_eff - IDX_W'(1);
                idx_zero_reg <= 1'b0;
                idx_last_reg <= 1'b1;
            end
        end
        if (cmd.cap_lo)
        begin
            x1_reg <= pt_rd_reg;
            y1_reg <= val_rd_reg;
        end
        if (cmd.prep)
        begin
            dx_reg    <= (pt_rd_reg >= x1_reg) ? pt_rd_reg - x1_reg : x1_reg - pt_rd_reg;
            dq_reg    <= (q >= x1_reg) ? q - x1_reg : x1_reg - q;
            dy_reg    <= (val_rd_reg >= y1_reg) ? val_rd_reg - y1_reg : y1_reg - val_rd_reg;
            neg_reg   <= (pt_rd_reg < x1_reg) ^ (q < x1_reg) ^ (val_rd_reg < y1_reg);
            fault_reg <= pt_rd_reg == x1_reg;
            if (below)
                region_reg <= REGION_BELOW;
            else if (above)
                region_reg <= REGION_ABOVE;
            else
                region_reg <= REGION_INSIDE;
        end
        if (cmd.mul_lo)
            prod_reg <= PROD_W'(part_prod);
        if (cmd.mul_hi)
        begin
            prod_reg    <= prod_reg + (PROD_W'(part_prod) << HALF_W);
            rem_reg     <= '0;
            div_cnt_reg <= '0;
        end
        // Restoring division, one quotient bit per cycle shifted in at the bottom
        if (cmd.div_step)
        begin
            rem_reg     <= rem_ge ? rem_diff[POINT_WIDTH-1:0] : rem_shift[POINT_WIDTH-1:0];
            prod_reg    <= {prod_reg[PROD_W-2:0], rem_ge};
            div_cnt_reg <= div_cnt_reg + CNT_W'(1);
        end
        if (cmd.combine)
            v_reg <= v_next;
        if (cmd.scale)
            gp_reg <= gp_next;
        if (cmd.out_load)
        begin
            out_item_reg.result_value <= sat[RESULT_W-1:0];
            out_item_reg.segment_low  <= seg_wide[INDEX_FIELD_W-1:0];
            out_item_reg.region       <= region_reg;
            out_item_reg.div_fault    <= fault_reg;
        end
    end

    assign out_valid_next = cmd.out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmp_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cmp_valid_reg <= cmp_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    assign status.in_is_query = in_item.opcode == OP_QUERY;
    assign status.search_done = hit;
    assign status.fault       = fault_reg;
    assign status.div_done    = div_cnt_reg == CNT_W'(PROD_W - 1);
    assign status.out_free    = !out_valid_reg || out_ready;

    `TLI_ASSERT_IMP(a_rem_below_divisor, cmd.div_step, rem_reg < dx_reg)
    `TLI_ASSERT_IMP(a_no_result_overwrite, cmd.out_load, !out_valid_reg || out_ready)
    `TLI_ASSERT_IMP(a_mul_nonzero_divisor, cmd.mul_lo, dx_reg != '0)
    `TLI_ASSERT_NEXT(a_search_stops, hit, !cmd.search)
    `TLI_ASSERT_NEXT(a_div_then_combine, cmd.div_step && status.div_done, cmd.combine)

endmodule

// File: rtl/tli_ctrl.sv
module tli_ctrl
    import tli_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  tli_status_t status,
    output tli_cmd_t    cmd
);

    typedef enum logic [12:0] {
        S_IDLE       = 13'b0_0000_0000_0001,
        S_LOAD_SLOT  = 13'b0_0000_0000_0010,
        S_LOAD_WRITE = 13'b0_0000_0000_0100,
        S_SEARCH     = 13'b0_0000_0000_1000,
        S_FETCH_LO   = 13'b0_0000_0001_0000,
        S_FETCH_HI   = 13'b0_0000_0010_0000,
        S_FETCH_WAIT = 13'b0_0000_0100_0000,
        S_MUL_LO     = 13'b0_0000_1000_0000,
        S_MUL_HI     = 13'b0_0001_0000_0000,
        S_DIVIDE     = 13'b0_0010_0000_0000,
        S_COMBINE    = 13'b0_0100_0000_0000,
        S_SCALE      = 13'b0_1000_0000_0000,
        S_EMIT       = 13'b1_0000_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = state_reg == S_IDLE;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = status.in_is_query ? S_SEARCH : S_LOAD_SLOT;
                end
            end
            S_LOAD_SLOT:
            begin
                cmd.slot_calc = 1'b1;
                state_next    = S_LOAD_WRITE;
            end
            S_LOAD_WRITE:
            begin
                cmd.mem_write = 1'b1;
                state_next    = S_IDLE;
            end
            S_SEARCH:
            begin
                cmd.search = 1'b1;
                if (status.search_done)
                    state_next = S_FETCH_LO;
            end
            S_FETCH_LO:
                state_next = S_FETCH_HI;
            S_FETCH_HI:
            begin
                cmd.fetch_hi = 1'b1;
                cmd.cap_lo   = 1'b1;
                state_next   = S_FETCH_WAIT;
            end
            S_FETCH_WAIT:
            begin
                cmd.prep   = 1'b1;
                state_next = S_MUL_LO;
            end
            S_MUL_LO:
            begin
                // equal breakpoints: skip the divide, keep the lower value
                if (status.fault)
                    state_next = S_COMBINE;
                else
                begin
                    cmd.mul_lo = 1'b1;
                    state_next = S_MUL_HI;
                end
            end
            S_MUL_HI:
            begin
                cmd.mul_hi = 1'b1;
                state_next = S_DIVIDE;
            end
            S_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                if (status.div_done)
                    state_next = S_COMBINE;
            end
            S_COMBINE:
            begin
                cmd.combine = 1'b1;
                state_next  = S_SCALE;
            end
            S_SCALE:
            begin
                cmd.scale  = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                // hold until the output register frees up
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// File: rtl/table_linear_interpolator.sv
// channel  signals                          direction
// in       in_valid, in_ready, in_item      into block, one load or query per item
// out      out_valid, out_ready, out_item   out of block, one result per query
// cfg      cfg_we, cfg_index, cfg_data      into block, write only, no wait
//
// A load captures the item, computes the slot and writes the table. A query runs a linear
// search with one table read per search step, fetches the segment, multiplies, then
// divides with one quotient bit per cycle from the restoring divider and scales.
// Equal breakpoints skip the multiply and the divide.
// Reset idles the controller and sets last_index to 205 and gain to 100; the table is
// undefined until loaded.
// A stalled output holds the finished result; the next item is taken while it waits.
module table_linear_interpolator
    import tli_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int POINT_WIDTH = POINT_WIDTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  tli_in_t               in_item,
    output logic                  out_valid,
    input  logic                  out_ready,
    output tli_out_t              out_item,
    input  logic                  cfg_we,
    input  cfg_index_t            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [INDEX_FIELD_W-1:0] last_index_reg;
    logic [GAIN_W-1:0]        gain_reg;
    tli_cmd_t                 cmd;
    tli_status_t              status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_index_reg <= LAST_INDEX_RESET;
            gain_reg       <= GAIN_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_LAST_INDEX: last_index_reg <= cfg_data[INDEX_FIELD_W-1:0];
                CFG_GAIN:       gain_reg       <= cfg_data[GAIN_W-1:0];
                default:        last_index_reg <= last_index_reg;
            endcase
        end
    end

    tli_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    tli_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .POINT_WIDTH (POINT_WIDTH)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_item    (in_item),
        .cmd        (cmd),
        .status     (status),
        .last_index (last_index_reg),
        .gain       (gain_reg),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_item   (out_item)
    );

endmodule

// File: dv/table_linear_interpolator_tb.sv
`timescale 1ns / 1ps

module table_linear_interpolator_tb;
    import tli_pkg::*;

    localparam int CYCLE_LIMIT  = 3_000_000;
    localparam int PHASE_BODY   = 78;
    localparam int LOAD_SETTLE  = 8;
    localparam int TAIL_CYCLES  = 20;
    localparam int MODE_SPAN    = 40;

    typedef enum logic [1:0] {ROW_LOAD, ROW_QUERY, ROW_CFG} row_kind_e;

    typedef struct {
        row_kind_e             kind;
        tli_in_t               item;
        cfg_index_t            reg_idx;
        logic [CFG_DATA_W-1:0] reg_data;
        bit                    typed;
        tli_out_t              want;
    } dir_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    tli_in_t               in_item = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b1;
    tli_out_t              out_item;
    logic                  cfg_we = 1'b0;
    cfg_index_t            cfg_index = CFG_LAST_INDEX;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // shadow copy of the table and registers
    logic [POINT_FIELD_W-1:0] breakpoints [0:255];
    logic [VALUE_W-1:0]       values [0:255];
    logic [INDEX_FIELD_W-1:0] last_index_reg = LAST_INDEX_RESET;
    logic [GAIN_W-1:0]        gain_reg = GAIN_RESET;

    tli_out_t awaited_results [$];
    int       mismatches = 0;
    int       results_seen = 0;
    int       items_sent = 0;
    int       cycle_count = 0;
    int       in_gap_max = 13;
    int       out_stall_max = 13;
    int       ready_hold = 0;

    table_linear_interpolator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic logic [POINT_FIELD_W-1:0] rand40();
        logic [63:0] w;
        w = {$urandom(), $urandom()};
        return w[POINT_FIELD_W-1:0];
    endfunction

    function automatic tli_in_t random_item(input logic op);
        tli_in_t it;
        it.opcode      = op;
        it.entry_index = 8'($urandom());
        it.entry_point = rand40();
        it.entry_value = $urandom();
        it.query_point = rand40();
        return it;
    endfunction

    // piecewise-linear lookup on the shadow table, scaled by gain and saturated
    function automatic tli_out_t interpolate(input logic [POINT_FIELD_W-1:0] q);
        tli_out_t                 res;
        int                       last;
        int                       idx;
        int                       lo;
        logic [POINT_FIELD_W-1:0] x1, x2, dx, dq;
        logic [VALUE_W-1:0]       y_lo, y_hi, dy;
        logic [127:0]             quot;
        logic [63:0]              mag;
        logic signed [63:0]       v, scaled;
        bit                       flip;
        last = (last_index_reg == 0) ? 1 : int'(last_index_reg);
        idx = 0;
        while (q > breakpoints[idx])
        begin
            idx++;
            if (idx >= last)
                break;
        end
        res.region = REGION_INSIDE;
        if (idx == 0 && q < breakpoints[0])
            res.region = REGION_BELOW;
        else if (idx == last && q > breakpoints[last])
            res.region = REGION_ABOVE;
        lo = (idx == 0) ? 0 : idx - 1;
        x1 = breakpoints[lo];
        x2 = breakpoints[lo + 1];
        y_lo = values[lo];
        y_hi = values[lo + 1];
        res.div_fault = (x1 == x2);
        if (res.div_fault)
            v = $signed({32'd0, y_lo});
        else
        begin
            flip = (x2 < x1) ^ (q < x1) ^ (y_hi < y_lo);
            dx = (x2 > x1) ? x2 - x1 : x1 - x2;
            dq = (q >= x1) ? q - x1 : x1 - q;
            dy = (y_hi >= y_lo) ? y_hi - y_lo : y_lo - y_hi;
            quot = (128'(dq) * 128'(dy)) / 128'(dx);
            // cap the quotient magnitude
            mag = (quot > (128'd1 << QUOT_CAP_BIT)) ? (64'd1 << QUOT_CAP_BIT) : quot[63:0];
            v = flip ? $signed({32'd0, y_lo}) - $signed(mag)
                     : $signed({32'd0, y_lo}) + $signed(mag);
        end
        scaled = v * $signed({54'd0, gain_reg});
        if (scaled > RES_MAX)
            scaled = RES_MAX;
        else if (scaled < RES_MIN)
            scaled = RES_MIN;
        res.result_value = scaled[RESULT_W-1:0];
        res.segment_low  = 8'(lo);
        return res;
    endfunction

    function automatic dir_row_t mk_load(input logic [7:0] slot,
                                         input logic [POINT_FIELD_W-1:0] pt,
                                         input logic [VALUE_W-1:0] val);
        dir_row_t row;
        row.kind             = ROW_LOAD;
        row.item             = random_item(OP_LOAD);
        row.item.entry_index = slot;
        row.item.entry_point = pt;
        row.item.entry_value = val;
        row.reg_idx          = CFG_LAST_INDEX;
        row.reg_data         = '0;
        row.typed            = 1'b0;
        row.want             = '0;
        return row;
    endfunction

    function automatic dir_row_t mk_query(input logic [POINT_FIELD_W-1:0] q);
        dir_row_t row;
        row.kind             = ROW_QUERY;
        row.item             = random_item(OP_QUERY);
        row.item.query_point = q;
        row.reg_idx          = CFG_LAST_INDEX;
        row.reg_data         = '0;
        row.typed            = 1'b0;
        row.want             = '0;
        return row;
    endfunction

    function automatic dir_row_t mk_query_exp(input logic [POINT_FIELD_W-1:0] q,
                                              input logic signed [RESULT_W-1:0] rv,
                                              input logic [7:0] seg,
                                              input region_t reg_code,
                                              input logic fault);
        dir_row_t row;
        row = mk_query(q);
        row.typed             = 1'b1;
        row.want.result_value = rv;
        row.want.segment_low  = seg;
        row.want.region       = reg_code;
        row.want.div_fault    = fault;
        return row;
    endfunction

    function automatic dir_row_t mk_cfg(input cfg_index_t idx,
                                        input logic [CFG_DATA_W-1:0] data);
        dir_row_t row;
        row.kind     = ROW_CFG;
        row.item     = '0;
        row.reg_idx  = idx;
        row.reg_data = data;
        row.typed    = 1'b0;
        row.want     = '0;
        return row;
    endfunction

    // present one item, wait for the handshake, then update the shadow state
    task automatic send_item(input tli_in_t item, input bit typed, input tli_out_t want);
        int gap;
        if (items_sent % MODE_SPAN == 0)
            in_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 13;
        gap = $urandom_range(0, in_gap_max);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_item  <= item;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
        if (item.opcode == OP_LOAD)
        begin
            breakpoints[item.entry_index] = item.entry_point;
            values[item.entry_index]      = item.entry_value;
        end
        else
            awaited_results.push_back(typed ? want : interpolate(item.query_point));
    endtask

    // registers change only with the block idle
    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] data);
        in_valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (LOAD_SETTLE) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_LAST_INDEX)
            last_index_reg = data[INDEX_FIELD_W-1:0];
        else
            gain_reg = data[GAIN_W-1:0];
    endtask

    task automatic fill_table(input int top);
        logic [40:0]              acc;
        logic [POINT_FIELD_W-1:0] step;
        int                       shape;
        int                       min_shift;
        tli_in_t                  it;
        shape = $urandom_range(0, 9);
        min_shift = (top > 16) ? 10 : 1;
        acc = {1'b0, rand40() >> $urandom_range(1, 40)};
        for (int s = 0; s <= top; s++)
        begin
            it = random_item(OP_LOAD);
            it.entry_index = 8'(s);
            if (shape == 0)
                it.entry_point = rand40();
            else
            begin
                it.entry_point = acc[POINT_FIELD_W-1:0];
                case ($urandom_range(0, 9))
                    0:       step = '0;
                    1, 2:    step = POINT_FIELD_W'($urandom_range(1, 3));
                    default: step = (shape < 3) ? POINT_FIELD_W'($urandom_range(0, 2))
                                                : rand40() >> $urandom_range(min_shift, 39);
                endcase
                acc = acc + {1'b0, step};
                if (acc[40])
                    acc = {1'b0, {POINT_FIELD_W{1'b1}}};
            end
            case ($urandom_range(0, 7))
                0:       it.entry_value = '0;
                1:       it.entry_value = '1;
                default: it.entry_value = $urandom();
            endcase
            send_item(it, 1'b0, '0);
        end
    endtask

    task automatic run_phase(input logic [CFG_DATA_W-1:0] last_data,
                             input logic [CFG_DATA_W-1:0] gain_data);
        int                       top;
        int                       k;
        int                       slot;
        logic [40:0]              mid;
        tli_in_t                  it;
        write_reg(CFG_LAST_INDEX, last_data);
        write_reg(CFG_GAIN, gain_data);
        top = (last_data[INDEX_FIELD_W-1:0] == 0) ? 1 : int'(last_data[INDEX_FIELD_W-1:0]);
        fill_table(top);
        for (int n = 0; n < PHASE_BODY; n++)
        begin
            k = $urandom_range(0, 9);
            if (k < 7)
            begin
                it = random_item(OP_QUERY);
                k = $urandom_range(0, top);
                case ($urandom_range(0, 7))
                    0, 1: it.query_point = breakpoints[k];
                    2:    it.query_point = breakpoints[k] + 1'b1;
                    3:    it.query_point = breakpoints[k] - 1'b1;
                    4:
                    begin
                        mid = (k < top) ? ({1'b0, breakpoints[k]} + {1'b0, breakpoints[k + 1]}) >> 1
                                        : {1'b0, breakpoints[k]};
                        it.query_point = mid[POINT_FIELD_W-1:0];
                    end
                    5:       it.query_point = ($urandom_range(0, 1) == 0) ? '0 : '1;
                    default: it.query_point = rand40();
                endcase
            end
            else
            begin
                it = random_item(OP_LOAD);
                // mostly keep the shape near a live slot, sometimes hit anywhere
                slot = (k < 9) ? $urandom_range(0, top) : $urandom_range(0, 255);
                it.entry_index = 8'(slot);
                // only live slots are known to hold a breakpoint
                if ($urandom_range(0, 1) == 0 && slot <= top)
                    it.entry_point = breakpoints[slot] + POINT_FIELD_W'($urandom_range(0, 3));
            end
            send_item(it, 1'b0, '0);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : result_check
        tli_out_t want;
        int       stall;
        if (!rst_n)
        begin
            out_ready  <= 1'b1;
            ready_hold <= 0;
        end
        else if (out_valid && out_ready)
        begin
            if (awaited_results.size() == 0)
            begin
                $error("result with no item waiting for it");
                mismatches++;
            end
            else
            begin
                want = awaited_results.pop_front();
                if (out_item.result_value !== want.result_value)
                begin
                    $error("result_value: expected %0d, got %0d",
                           want.result_value, out_item.result_value);
                    mismatches++;
                end
                if (out_item.segment_low !== want.segment_low)
                begin
                    $error("segment_low: expected %0d, got %0d",
                           want.segment_low, out_item.segment_low);
                    mismatches++;
                end
                if (out_item.region !== want.region)
                begin
                    $error("region: expected %0d, got %0d", want.region, out_item.region);
                    mismatches++;
                end
                if (out_item.div_fault !== want.div_fault)
                begin
                    $error("div_fault: expected %0d, got %0d",
                           want.div_fault, out_item.div_fault);
                    mismatches++;
                end
            end
            results_seen++;
            if (results_seen % 32 == 0)
                out_stall_max = ($urandom_range(0, 2) == 0) ? 0 : 13;
            stall = $urandom_range(0, out_stall_max);
            if (stall != 0)
            begin
                out_ready  <= 1'b0;
                ready_hold <= stall;
            end
        end
        else if (out_valid && !out_ready)
        begin
            // count the stall only while a result is waiting
            if (ready_hold <= 1)
                out_ready <= 1'b1;
            ready_hold <= ready_hold - 1;
        end
    end

    initial
    begin : stimulus
        dir_row_t plan [$];

        // reset registers: last_index 205, gain 100
        plan.push_back(mk_load(8'd0, 40'd100, 32'h0001_0000));
        plan.push_back(mk_load(8'd1, 40'd200, 32'h0003_0000));
        plan.push_back(mk_load(8'd2, 40'd300, 32'h0002_0000));
        plan.push_back(mk_load(8'd3, 40'd300, 32'h0005_0000));
        plan.push_back(mk_load(8'd4, 40'hFF_FFFF_FFFF, 32'hFFFF_FFFF));
        plan.push_back(mk_query_exp(40'd100, 48'sd6553600, 8'd0, REGION_INSIDE, 1'b0));
        plan.push_back(mk_query_exp(40'd50, 48'sd0, 8'd0, REGION_BELOW, 1'b0));
        plan.push_back(mk_query_exp(40'd0, -48'sd6553600, 8'd0, REGION_BELOW, 1'b0));
        plan.push_back(mk_query(40'd150));
        plan.push_back(mk_query(40'd300));
        plan.push_back(mk_query(40'd301));
        plan.push_back(mk_query_exp(40'hFF_FFFF_FFFF, 48'sd429496729500, 8'd3,
                                    REGION_INSIDE, 1'b0));
        // equal breakpoints at the end of a short table
        plan.push_back(mk_cfg(CFG_LAST_INDEX, 10'd3));
        plan.push_back(mk_cfg(CFG_GAIN, 10'd1023));
        plan.push_back(mk_query_exp(40'd400, 48'sd134086656, 8'd2, REGION_ABOVE, 1'b1));
        plan.push_back(mk_query(40'hFF_FFFF_FFFF));
        plan.push_back(mk_query(40'd0));
        plan.push_back(mk_cfg(CFG_GAIN, 10'd0));
        plan.push_back(mk_query_exp(40'd150, 48'sd0, 8'd0, REGION_INSIDE, 1'b0));
        // upper data bits are ignored for last_index
        plan.push_back(mk_cfg(CFG_LAST_INDEX, 10'h301));
        plan.push_back(mk_cfg(CFG_GAIN, 10'd1023));
        plan.push_back(mk_query_exp(40'hFF_FFFF_FFFF, RES_MAX[RESULT_W-1:0], 8'd0,
                                    REGION_ABOVE, 1'b0));
        // steep segment far below: capped quotient, negative saturation
        plan.push_back(mk_load(8'd0, 40'hFF_FFFF_FFFE, 32'h0000_0000));
        plan.push_back(mk_load(8'd1, 40'hFF_FFFF_FFFF, 32'hFFFF_FFFF));
        plan.push_back(mk_query_exp(40'd0, RES_MIN[RESULT_W-1:0], 8'd0, REGION_BELOW, 1'b0));
        plan.push_back(mk_load(8'd255, 40'd0, 32'd0));
        plan.push_back(mk_load(8'd1, 40'hFF_FFFF_FFFE, 32'd7));
        plan.push_back(mk_query_exp(40'd5, 48'sd0, 8'd0, REGION_BELOW, 1'b1));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_CFG)
                write_reg(plan[i].reg_idx, plan[i].reg_data);
            else
                send_item(plan[i].item, plan[i].typed, plan[i].want);
        end

        run_phase(10'd1, 10'd1);
        run_phase(10'd2, 10'd1023);
        run_phase(10'($urandom_range(3, 12)), 10'd0);
        run_phase({2'($urandom_range(1, 3)), 8'd0}, 10'($urandom_range(0, 1023)));
        run_phase(10'd255, 10'd100);
        run_phase(10'($urandom_range(4, 40)), 10'($urandom_range(0, 1023)));
        run_phase(10'd205, 10'($urandom_range(1, 1023)));
        run_phase(10'($urandom_range(1, 255)), 10'd1023);

        in_valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
